### rtl/gtpg_pkg.sv
// ----------------------------------------------------------------------------
// gtpg_pkg
// Shared types, constants and the glyph font for the text pixel generator.
// ----------------------------------------------------------------------------
package gtpg_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned GlyphPx   = 16;
  localparam int unsigned PxIdxW    = 4;

  localparam logic [7:0] ByteNul    = 8'h00;
  localparam logic [7:0] BytePrefix = 8'hC3;
  localparam logic [7:0] ByteLf     = 8'd10;
  localparam logic [7:0] ByteCr     = 8'd13;
  localparam logic [CoordBits-1:0] AdvanceX = CoordBits'(6);
  localparam logic [CoordBits-1:0] LineStep = CoordBits'(10);

  localparam logic [1:0] RegInkColor = 2'd0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]  pixel_color;
    logic        last_pixel;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_start;   // take start position
    logic newline;      // back to origin, down a line
    logic set_prefix;
    logic clr_prefix;
    logic load_glyph;   // latch glyph and clear pixel index
    logic emit;         // push current pixel into output register
    logic step;         // next pixel
    logic advance;      // cursor x += 6
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic prefix;
    logic px_set;       // current pixel slot used
    logic px_last;      // current pixel is final of glyph
  } dp_sts_t;

  typedef logic [6:0] px_code_t;              // {row+2, col+1}
  typedef logic [GlyphPx*7-1:0] glyph_row_t;

  function automatic px_code_t d(input int cx, input int cy);
    return px_code_t'((cx + 1) | ((cy + 2) << 3));
  endfunction

  function automatic glyph_row_t g(input px_code_t p0 = '0, input px_code_t p1 = '0,
      input px_code_t p2 = '0, input px_code_t p3 = '0, input px_code_t p4 = '0,
      input px_code_t p5 = '0, input px_code_t p6 = '0, input px_code_t p7 = '0,
      input px_code_t p8 = '0, input px_code_t p9 = '0, input px_code_t p10 = '0,
      input px_code_t p11 = '0, input px_code_t p12 = '0, input px_code_t p13 = '0,
      input px_code_t p14 = '0, input px_code_t p15 = '0);
    return {p15, p14, p13, p12, p11, p10, p9, p8, p7, p6, p5, p4, p3, p2, p1, p0};
  endfunction

  // Glyph lookup: key bit 8 marks a byte that follows the UTF-8 prefix.
  function automatic glyph_row_t font_lookup(input logic [8:0] key);
    glyph_row_t r;
    r = '0;
    case (key)
      9'h1A1: r = g(d(3,-2),d(2,-1),d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5),d(4,5));
      9'h1A9: r = g(d(3,-2),d(2,-1),d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(1,3),d(2,3),
                    d(0,4),d(1,5),d(2,5));
      9'h1AD: r = g(d(3,-1),d(2,0),d(1,2),d(2,2),d(2,3),d(2,4),d(2,5));
      9'h1B3: r = g(d(3,-2),d(2,-1),d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h1BA: r = g(d(3,-2),d(2,-1),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5),d(4,5));
      9'h1B1: r = g(d(0,0),d(1,0),d(2,0),d(0,2),d(1,2),d(2,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(0,5),d(3,5));
      9'h191: r = g(d(1,-1),d(2,-1),d(3,-1),d(0,1),d(4,1),d(0,2),d(1,2),d(4,2),d(0,3),
                    d(2,3),d(4,3),d(0,4),d(3,4),d(4,4),d(0,5),d(4,5));
      9'h061: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5),d(4,5));
      9'h062: r = g(d(0,0),d(0,1),d(0,2),d(1,2),d(2,2),d(0,3),d(3,3),d(0,4),d(3,4),
                    d(0,5),d(1,5),d(2,5));
      9'h063: r = g(d(1,1),d(2,1),d(0,2),d(0,3),d(0,4),d(1,5),d(2,5));
      9'h064: r = g(d(3,0),d(3,1),d(1,2),d(2,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),
                    d(1,5),d(2,5),d(3,5));
      9'h065: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(1,3),d(2,3),d(0,4),d(1,5),
                    d(2,5));
      9'h066: r = g(d(2,0),d(3,0),d(1,1),d(1,2),d(2,2),d(3,2),d(1,3),d(1,4),d(1,5));
      9'h067: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5),d(3,5),d(3,6),d(1,7),d(2,7));
      9'h068: r = g(d(0,0),d(0,1),d(0,2),d(1,2),d(2,2),d(0,3),d(3,3),d(0,4),d(3,4),
                    d(0,5),d(3,5));
      9'h069: r = g(d(2,0),d(1,2),d(2,2),d(2,3),d(2,4),d(2,5));
      9'h06A: r = g(d(2,0),d(2,2),d(2,3),d(2,4),d(2,5),d(1,6));
      9'h06B: r = g(d(1,1),d(3,1),d(1,2),d(2,2),d(1,3),d(3,3),d(1,4),d(4,4),d(1,5),
                    d(4,5));
      9'h06C: r = g(d(1,0),d(1,1),d(1,2),d(1,3),d(1,4),d(2,5));
      9'h06D: r = g(d(0,1),d(1,1),d(3,1),d(0,2),d(2,2),d(4,2),d(0,3),d(2,3),d(4,3),
                    d(0,4),d(2,4),d(4,4),d(0,5),d(2,5),d(4,5));
      9'h06E: r = g(d(0,1),d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),
                    d(0,5),d(3,5));
      9'h06F: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5));
      9'h070: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(0,5),
                    d(1,5),d(2,5),d(0,6),d(0,7));
      9'h071: r = g(d(1,1),d(2,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5),d(3,5),d(3,6),d(3,7));
      9'h072: r = g(d(0,1),d(2,1),d(3,1),d(0,2),d(1,2),d(0,3),d(0,4),d(0,5));
      9'h073: r = g(d(1,1),d(2,1),d(3,1),d(0,2),d(1,3),d(2,3),d(3,4),d(0,5),d(1,5),
                    d(2,5));
      9'h074: r = g(d(1,0),d(1,1),d(2,1),d(1,2),d(1,3),d(1,4),d(2,5),d(3,5));
      9'h075: r = g(d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5),d(4,5));
      9'h076: r = g(d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),d(2,4),d(1,5));
      9'h077: r = g(d(0,1),d(2,1),d(4,1),d(0,2),d(2,2),d(4,2),d(0,3),d(2,3),d(4,3),
                    d(0,4),d(2,4),d(4,4),d(1,5),d(2,5),d(3,5));
      9'h078: r = g(d(0,1),d(4,1),d(1,2),d(3,2),d(2,3),d(1,4),d(3,4),d(0,5),d(4,5));
      9'h079: r = g(d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(1,4),d(2,4),d(3,4),
                    d(3,5),d(1,6),d(2,6));
      9'h07A: r = g(d(0,1),d(1,1),d(2,1),d(3,1),d(4,1),d(3,2),d(2,3),d(1,4),d(0,5),
                    d(1,5),d(2,5),d(3,5),d(4,5));
      9'h031: r = g(d(2,0),d(1,1),d(2,1),d(2,2),d(2,3),d(2,4),d(2,5));
      9'h032: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(3,2),d(2,3),d(1,4),d(0,5),d(1,5),
                    d(2,5),d(3,5));
      9'h033: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(2,2),d(3,3),d(0,4),d(3,4),d(1,5),
                    d(2,5));
      9'h034: r = g(d(3,0),d(2,1),d(3,1),d(1,2),d(3,2),d(0,3),d(1,3),d(2,3),d(3,3),
                    d(3,4),d(3,5));
      9'h035: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(0,1),d(0,2),d(1,2),d(2,2),d(3,3),
                    d(0,4),d(3,4),d(1,5),d(2,5));
      9'h036: r = g(d(1,0),d(2,0),d(0,1),d(0,2),d(1,2),d(2,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h037: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(3,1),d(3,2),d(2,3),d(2,4),d(2,5));
      9'h038: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(1,2),d(2,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h039: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(1,3),d(2,3),d(3,3),
                    d(3,4),d(1,5),d(2,5));
      9'h030: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h041: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(1,3),d(2,3),
                    d(3,3),d(0,4),d(3,4),d(0,5),d(3,5));
      9'h042: r = g(d(0,0),d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(1,2),d(2,2),d(0,3),
                    d(3,3),d(0,4),d(3,4),d(0,5),d(1,5),d(2,5));
      9'h043: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(0,3),d(0,4),d(3,4),d(1,5),
                    d(2,5));
      9'h044: r = g(d(0,0),d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),
                    d(0,4),d(3,4),d(0,5),d(1,5),d(2,5));
      9'h045: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(0,1),d(0,2),d(1,2),d(2,2),d(0,3),
                    d(0,4),d(0,5),d(1,5),d(2,5),d(3,5));
      9'h046: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(0,1),d(0,2),d(1,2),d(2,2),d(0,3),
                    d(0,4),d(0,5));
      9'h047: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(0,3),d(2,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h048: r = g(d(0,0),d(3,0),d(0,1),d(3,1),d(0,2),d(1,2),d(2,2),d(3,2),d(0,3),
                    d(3,3),d(0,4),d(3,4),d(0,5),d(3,5));
      9'h049: r = g(d(1,0),d(2,0),d(3,0),d(2,1),d(2,2),d(2,3),d(2,4),d(1,5),d(2,5),
                    d(3,5));
      9'h04A: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(2,1),d(2,2),d(2,3),d(2,4),d(0,5),
                    d(1,5));
      9'h04B: r = g(d(0,0),d(3,0),d(0,1),d(2,1),d(0,2),d(1,2),d(0,3),d(2,3),d(0,4),
                    d(3,4),d(0,5),d(4,5));
      9'h04C: r = g(d(0,0),d(0,1),d(0,2),d(0,3),d(0,4),d(0,5),d(1,5),d(2,5),d(3,5));
      9'h04D: r = g(d(0,0),d(4,0),d(0,1),d(1,1),d(3,1),d(4,1),d(0,2),d(2,2),d(4,2),
                    d(0,3),d(4,3),d(0,4),d(4,4),d(0,5),d(4,5));
      9'h04E: r = g(d(0,0),d(4,0),d(0,1),d(1,1),d(4,1),d(0,2),d(2,2),d(4,2),d(0,3),
                    d(3,3),d(4,3),d(0,4),d(4,4),d(0,5),d(4,5));
      9'h04F: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h050: r = g(d(0,0),d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(1,3),
                    d(2,3),d(0,4),d(0,5));
      9'h051: r = g(d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(2,4),d(3,4),d(1,5),d(2,5),d(3,6));
      9'h052: r = g(d(0,0),d(1,0),d(2,0),d(0,1),d(3,1),d(0,2),d(1,2),d(2,2),d(0,3),
                    d(3,3),d(0,4),d(3,4),d(0,5),d(3,5));
      9'h053: r = g(d(1,0),d(2,0),d(3,0),d(0,1),d(1,2),d(2,2),d(3,3),d(3,4),d(0,5),
                    d(1,5),d(2,5));
      9'h054: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(4,0),d(2,1),d(2,2),d(2,3),d(2,4),
                    d(2,5));
      9'h055: r = g(d(0,0),d(3,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(3,3),d(0,4),
                    d(3,4),d(1,5),d(2,5));
      9'h056: r = g(d(0,0),d(3,0),d(0,1),d(3,1),d(0,2),d(3,2),d(0,3),d(2,3),d(0,4),
                    d(2,4),d(1,5));
      9'h057: r = g(d(0,0),d(4,0),d(0,1),d(4,1),d(0,2),d(4,2),d(0,3),d(4,3),d(0,4),
                    d(2,4),d(4,4),d(1,5),d(3,5));
      9'h058: r = g(d(0,0),d(4,0),d(1,1),d(3,1),d(2,2),d(1,3),d(3,3),d(0,4),d(4,4),
                    d(0,5),d(4,5));
      9'h059: r = g(d(0,0),d(4,0),d(0,1),d(4,1),d(1,2),d(3,2),d(2,3),d(2,4),d(2,5));
      9'h05A: r = g(d(0,0),d(1,0),d(2,0),d(3,0),d(4,0),d(3,1),d(2,2),d(1,3),d(0,4),
                    d(0,5),d(1,5),d(2,5),d(3,5),d(4,5));
      9'h03A: r = g(d(2,2),d(2,5));
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/glyph_text_pixel_generator.sv
// ----------------------------------------------------------------------------
// glyph_text_pixel_generator
// Renders a text byte stream into pixel write beats with a fixed font.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_item_i): a start beat (kind 0)
// sets cursor and line origin; a byte beat (kind 1) draws one character.
// Output channel (out_valid_o/out_ready_i, out_item_o): one beat per set
// pixel, last_pixel marking the final one of a glyph.
// Control bytes (start, NUL, 0xC3 prefix, LF, CR) make no output. A glyph
// byte is first looked up into the glyph register, then the pixel sequencer
// emits its pixels (up to 16) one by one; a byte with no glyph makes no
// output and advances the cursor. out_valid_o rises once the glyph is loaded
// and its first pixel is registered. Input is not taken while a glyph is drawn.
// The next pixel loads into the output register in the cycle the waiting
// beat is taken, so while a glyph is drawn a receiver that never stalls gets
// one beat per cycle; when it stalls the sequencer holds on the current pixel.
// Reset clears the cursor, origin and prefix flag; ink_color resets to 255.
// ink_color is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module glyph_text_pixel_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gtpg_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gtpg_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gtpg_pkg::*;

  logic [7:0] ink_q;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  out_item_t  pix;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       take;

  assign pready = 1'b1;
  assign prdata = (paddr == RegInkColor) ? {24'd0, ink_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q <= 8'hFF;
    end else if (psel && penable && pwrite && paddr == RegInkColor) begin
      ink_q <= pwdata[7:0];
    end
  end

  assign take = out_valid_q && out_ready_i;

  gtpg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_kind_i  (in_item_i.kind),
    .in_byte_i  (in_item_i.char_byte),
    .in_ready_o,
    .out_full_i (out_valid_q),
    .out_take_i (take),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gtpg_dp u_dp (
    .clk_i,
    .rst_ni,
    .in_item_i,
    .ink_i (ink_q),
    .cmd_i (cmd),
    .sts_o (sts),
    .pix_o (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a new beat never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");

  // no input taken while drawing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready_o)
    else $error("input accepted mid glyph");

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled beat changed");

endmodule

### rtl/gtpg_ctrl.sv
// ----------------------------------------------------------------------------
// gtpg_ctrl
// Sequencer: decodes each input beat and walks the glyph pixels.
// ----------------------------------------------------------------------------
module gtpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              out_full_i,   // output register holds an untaken beat
  input  logic              out_take_i,   // that beat taken this cycle
  input  gtpg_pkg::dp_sts_t sts_i,
  output gtpg_pkg::dp_cmd_t cmd_o
);
  import gtpg_pkg::*;

  state_e state_q, state_d;
  logic   acc;
  logic   slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign slot_free  = !out_full_i || out_take_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && in_kind_i && (sts_i.prefix || (in_byte_i != BytePrefix &&
            in_byte_i != ByteLf && in_byte_i != ByteCr)) && in_byte_i != ByteNul) begin
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (!sts_i.px_set || (slot_free && sts_i.px_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!in_kind_i) begin
            cmd_o.load_start = 1'b1;
          end else if (sts_i.prefix) begin
            cmd_o.clr_prefix = 1'b1;
            cmd_o.load_glyph = (in_byte_i != ByteNul);
          end else if (in_byte_i == BytePrefix) begin
            cmd_o.set_prefix = 1'b1;
          end else if (in_byte_i == ByteLf || in_byte_i == ByteCr) begin
            cmd_o.newline = 1'b1;
          end else if (in_byte_i != ByteNul) begin
            cmd_o.load_glyph = 1'b1;
          end
        end
      end
      ST_DRAW: begin
        if (!sts_i.px_set) begin
          cmd_o.advance = 1'b1;
        end else if (slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.step    = 1'b1;
          cmd_o.advance = sts_i.px_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/gtpg_dp.sv
// ----------------------------------------------------------------------------
// gtpg_dp
// Datapath: cursor, line origin, glyph register and pixel address adders.
// ----------------------------------------------------------------------------
module gtpg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtpg_pkg::in_item_t  in_item_i,
  input  logic [7:0]          ink_i,
  input  gtpg_pkg::dp_cmd_t   cmd_i,
  output gtpg_pkg::dp_sts_t   sts_o,
  output gtpg_pkg::out_item_t pix_o
);
  import gtpg_pkg::*;

  logic [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, org_x_q, org_x_d;
  logic                 prefix_q, prefix_d;
  glyph_row_t           glyph_q;
  logic [PxIdxW-1:0]    idx_q;
  px_code_t             code, code_nx;
  logic                 at_end;

  assign code    = glyph_q[idx_q*7 +: 7];
  assign at_end  = (idx_q == PxIdxW'(GlyphPx - 1));
  assign code_nx = at_end ? '0 : glyph_q[(idx_q + PxIdxW'(1))*7 +: 7];

  assign sts_o.prefix  = prefix_q;
  assign sts_o.px_set  = (code != '0);
  assign sts_o.px_last = (code_nx == '0);

  // offset: column = code[2:0]-1, row = code[6:3]-2
  assign pix_o.pixel_x     = 16'(cur_x_q + CoordBits'(code[2:0]) - CoordBits'(1));
  assign pix_o.pixel_y     = 16'(cur_y_q + CoordBits'(code[6:3]) - CoordBits'(2));
  assign pix_o.pixel_color = ink_i;
  assign pix_o.last_pixel  = sts_o.px_last;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    org_x_d  = org_x_q;
    prefix_d = prefix_q;
    if (cmd_i.load_start) begin
      cur_x_d  = CoordBits'(in_item_i.start_x);
      org_x_d  = CoordBits'(in_item_i.start_x);
      cur_y_d  = CoordBits'(in_item_i.start_y);
      prefix_d = 1'b0;
    end
    if (cmd_i.newline) begin
      cur_x_d = org_x_q;
      cur_y_d = cur_y_q + LineStep;
    end
    if (cmd_i.set_prefix) prefix_d = 1'b1;
    if (cmd_i.clr_prefix) prefix_d = 1'b0;
    if (cmd_i.advance)    cur_x_d  = cur_x_q + AdvanceX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      org_x_q  <= '0;
      prefix_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      org_x_q  <= org_x_d;
      prefix_q <= prefix_d;
      if (cmd_i.load_glyph) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + PxIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_glyph) begin
      glyph_q <= font_lookup({prefix_q, in_item_i.char_byte});
    end
  end

endmodule
